[hw/rtl/mau_pkg.sv]
// Shared types and constants for the modular arithmetic unit.
package mau_pkg;

  localparam int DATA_WIDTH = 63;              // operand bits taken from each field
  localparam int MOD_W      = 62;              // modulus and residue width
  localparam int SUM_W      = MOD_W + 2;       // x + y + carry without overflow
  localparam int CNT_W      = $clog2(DATA_WIDTH);
  localparam int OPA_LSB    = 0;               // operand_a position in in_tdata
  localparam int OPB_LSB    = OPA_LSB + DATA_WIDTH; // operand_b position in in_tdata
  localparam int IN_DATA_W  = ((2 * DATA_WIDTH + 7) / 8) * 8;
  localparam int OUT_DATA_W = 64;

  localparam logic [MOD_W-1:0] MODULUS_RESET = MOD_W'(64'd1000000007);

  typedef enum logic [1:0] {
    MODE_ADD = 2'd0,
    MODE_MUL = 2'd1,
    MODE_POW = 2'd2,
    MODE_NOP = 2'd3
  } mode_t;

  // One request to a modular adder lane: (x + y + cin) mod m, with x, y below m.
  typedef struct packed {
    logic [MOD_W-1:0] x;
    logic [MOD_W-1:0] y;
    logic             cin;
  } lane_in_t;

endpackage

[hw/rtl/mau_modadd.sv]
// Modular adder lane: one add and one conditional subtract of the modulus.
module mau_modadd (
  input  mau_pkg::lane_in_t               lane_in,
  input  logic [mau_pkg::MOD_W-1:0]       modulus,
  output logic [mau_pkg::MOD_W-1:0]       sum_mod
);

  logic [mau_pkg::SUM_W-1:0] sum;
  logic [mau_pkg::SUM_W-1:0] m_ext;
  logic [mau_pkg::SUM_W-1:0] diff;

  assign sum   = {2'b00, lane_in.x} + {2'b00, lane_in.y}
               + {{(mau_pkg::SUM_W-1){1'b0}}, lane_in.cin};
  assign m_ext = {2'b00, modulus};
  assign diff  = sum - m_ext;

  // inputs below m keep the sum below 2m, so one subtract is enough
  assign sum_mod = (sum >= m_ext) ? diff[mau_pkg::MOD_W-1:0] : sum[mau_pkg::MOD_W-1:0];

endmodule

[hw/rtl/modular_arithmetic_unit.sv]
// Top level of the modular arithmetic unit: sequencer, datapath registers and ports.
//
// Each request carries a mode (in_tuser) and two operands (in_tdata) and yields
// one result reduced modulo the 62-bit modulus register (reset 1000000007,
// written through cfg_we/cfg_wdata; the user must write it only while the unit is
// idle, which the block does not enforce). Mode 0 adds, mode 1 multiplies, mode 2
// raises operand_a to the power operand_b (exponent zero gives 1 mod m); mode 3,
// or a modulus of zero, returns 0 and skips the reduction. All work runs through
// two modular adder lanes under one sequencer and the unit takes one request at
// a time. Steps: both operands are first reduced together, one bit per cycle.
// Add then runs one add state. Multiply handles one bit of the reduced multiplier
// per cycle and ends once no set bit is left. Power performs, per exponent bit, a
// squaring and, for set bits, a multiply, each a multiply as above preceded by a
// check state; the squaring after the top exponent bit is skipped. Every mode ends
// in the done state, which loads the output register.
// The result sits in an output register, so in_tready returns high as soon as
// it has been loaded there, even while out_tready is low.
module modular_arithmetic_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  // input requests
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [mau_pkg::IN_DATA_W-1:0]     in_tdata,   // [62:0] operand_a, [125:63] operand_b
  input  logic [1:0]                        in_tuser,   // [1:0] mode
  // results
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [mau_pkg::OUT_DATA_W-1:0]    out_tdata,  // [61:0] result
  // modulus register
  input  logic                              cfg_we,
  input  logic [mau_pkg::MOD_W-1:0]         cfg_wdata
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_ADD,
    ST_MUL,
    ST_POW_CHECK,
    ST_DONE
  } state_t;

  typedef enum logic {
    DST_ACC,
    DST_BASE
  } mul_dst_t;

  state_t                              state_r, state_nxt;
  mau_pkg::mode_t                      mode_r, mode_nxt;
  logic [mau_pkg::MOD_W-1:0]           modulus_r;
  logic [mau_pkg::DATA_WIDTH-1:0]      op_a_r, op_a_nxt;   // operand bits, shifted out MSB first
  logic [mau_pkg::DATA_WIDTH-1:0]      op_b_r, op_b_nxt;
  logic [mau_pkg::CNT_W-1:0]           cnt_r, cnt_nxt;
  logic [mau_pkg::MOD_W-1:0]           red_a_r, red_a_nxt; // running remainders
  logic [mau_pkg::MOD_W-1:0]           red_b_r, red_b_nxt;
  logic [mau_pkg::MOD_W-1:0]           mul_acc_r, mul_acc_nxt;
  logic [mau_pkg::MOD_W-1:0]           mul_x_r, mul_x_nxt;
  logic [mau_pkg::MOD_W-1:0]           mul_y_r, mul_y_nxt;
  mul_dst_t                            mul_dst_r, mul_dst_nxt;
  logic [mau_pkg::MOD_W-1:0]           pw_acc_r, pw_acc_nxt;
  logic [mau_pkg::MOD_W-1:0]           pw_base_r, pw_base_nxt;
  logic [mau_pkg::DATA_WIDTH-1:0]      pw_exp_r, pw_exp_nxt;
  logic                                pw_sq_r, pw_sq_nxt;  // set bit handled, square next
  logic [mau_pkg::MOD_W-1:0]           res_r, res_nxt;
  logic                                out_tvalid_r, out_tvalid_nxt;
  logic [mau_pkg::OUT_DATA_W-1:0]      out_tdata_r, out_tdata_nxt;

  mau_pkg::lane_in_t                   lane0_in, lane1_in;
  logic [mau_pkg::MOD_W-1:0]           lane0_out, lane1_out;
  logic [mau_pkg::MOD_W-1:0]           one_mod;
  logic                                in_fire;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // 1 mod m: zero only for a modulus of one
  assign one_mod = (modulus_r == mau_pkg::MOD_W'(1)) ? '0 : mau_pkg::MOD_W'(1);

  // lane 0: reduce operand_a, final add, or the accumulate step of a multiply
  // lane 1: reduce operand_b, or the doubling step of a multiply
  always_comb begin
    case (state_r)
      ST_REDUCE: begin
        lane0_in = '{x: red_a_r, y: red_a_r, cin: op_a_r[mau_pkg::DATA_WIDTH-1]};
        lane1_in = '{x: red_b_r, y: red_b_r, cin: op_b_r[mau_pkg::DATA_WIDTH-1]};
      end
      ST_ADD: begin
        lane0_in = '{x: red_a_r, y: red_b_r, cin: 1'b0};
        lane1_in = '{x: mul_x_r, y: mul_x_r, cin: 1'b0};
      end
      default: begin
        lane0_in = '{x: mul_acc_r, y: mul_x_r, cin: 1'b0};
        lane1_in = '{x: mul_x_r, y: mul_x_r, cin: 1'b0};
      end
    endcase
  end

  mau_modadd u_lane0 (
    .lane_in (lane0_in),
    .modulus (modulus_r),
    .sum_mod (lane0_out)
  );

  mau_modadd u_lane1 (
    .lane_in (lane1_in),
    .modulus (modulus_r),
    .sum_mod (lane1_out)
  );

  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    op_a_nxt       = op_a_r;
    op_b_nxt       = op_b_r;
    cnt_nxt        = cnt_r;
    red_a_nxt      = red_a_r;
    red_b_nxt      = red_b_r;
    mul_acc_nxt    = mul_acc_r;
    mul_x_nxt      = mul_x_r;
    mul_y_nxt      = mul_y_r;
    mul_dst_nxt    = mul_dst_r;
    pw_acc_nxt     = pw_acc_r;
    pw_base_nxt    = pw_base_r;
    pw_exp_nxt     = pw_exp_r;
    pw_sq_nxt      = pw_sq_r;
    res_nxt        = res_r;
    out_tdata_nxt  = out_tdata_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          mode_nxt   = mau_pkg::mode_t'(in_tuser);
          op_a_nxt   = in_tdata[mau_pkg::OPA_LSB +: mau_pkg::DATA_WIDTH];
          op_b_nxt   = in_tdata[mau_pkg::OPB_LSB +: mau_pkg::DATA_WIDTH];
          pw_exp_nxt = in_tdata[mau_pkg::OPB_LSB +: mau_pkg::DATA_WIDTH];
          red_a_nxt  = '0;
          red_b_nxt  = '0;
          cnt_nxt    = mau_pkg::CNT_W'(mau_pkg::DATA_WIDTH - 1);
          if (modulus_r == '0 || mau_pkg::mode_t'(in_tuser) == mau_pkg::MODE_NOP) begin
            res_nxt   = '0;
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_REDUCE;
          end
        end
      end

      ST_REDUCE: begin
        // restoring remainder, one operand bit per cycle, both operands at once
        red_a_nxt = lane0_out;
        red_b_nxt = lane1_out;
        op_a_nxt  = op_a_r << 1;
        op_b_nxt  = op_b_r << 1;
        cnt_nxt   = cnt_r - mau_pkg::CNT_W'(1);
        if (cnt_r == '0) begin
          case (mode_r)
            mau_pkg::MODE_ADD: begin
              state_nxt = ST_ADD;
            end
            mau_pkg::MODE_MUL: begin
              mul_acc_nxt = '0;
              mul_x_nxt   = lane0_out;
              mul_y_nxt   = lane1_out;
              mul_dst_nxt = DST_ACC;
              state_nxt   = ST_MUL;
            end
            default: begin
              pw_acc_nxt  = one_mod;
              pw_base_nxt = lane0_out;
              pw_sq_nxt   = 1'b0;
              state_nxt   = ST_POW_CHECK;
            end
          endcase
        end
      end

      ST_ADD: begin
        res_nxt   = lane0_out;
        state_nxt = ST_DONE;
      end

      ST_MUL: begin
        // shift-and-add: accumulate when the multiplier bit is set, double x
        if (mul_y_r == '0) begin
          if (mode_r == mau_pkg::MODE_MUL) begin
            res_nxt   = mul_acc_r;
            state_nxt = ST_DONE;
          end else begin
            if (mul_dst_r == DST_ACC) begin
              pw_acc_nxt = mul_acc_r;
            end else begin
              pw_base_nxt = mul_acc_r;
            end
            state_nxt = ST_POW_CHECK;
          end
        end else begin
          if (mul_y_r[0]) begin
            mul_acc_nxt = lane0_out;
          end
          mul_x_nxt = lane1_out;
          mul_y_nxt = mul_y_r >> 1;
        end
      end

      ST_POW_CHECK: begin
        // exponent scanned from its LSB: multiply on a set bit, then square
        if (pw_exp_r == '0) begin
          res_nxt   = pw_acc_r;
          state_nxt = ST_DONE;
        end else if (pw_exp_r[0] && !pw_sq_r) begin
          mul_acc_nxt = '0;
          mul_x_nxt   = pw_acc_r;
          mul_y_nxt   = pw_base_r;
          mul_dst_nxt = DST_ACC;
          pw_sq_nxt   = 1'b1;
          state_nxt   = ST_MUL;
        end else begin
          pw_exp_nxt = pw_exp_r >> 1;
          pw_sq_nxt  = 1'b0;
          if ((pw_exp_r >> 1) == '0) begin
            // last bit done, the squared base would go unused
            res_nxt   = pw_acc_r;
            state_nxt = ST_DONE;
          end else begin
            mul_acc_nxt = '0;
            mul_x_nxt   = pw_base_r;
            mul_y_nxt   = pw_base_r;
            mul_dst_nxt = DST_BASE;
            state_nxt   = ST_MUL;
          end
        end
      end

      ST_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tdata_nxt  = {{(mau_pkg::OUT_DATA_W - mau_pkg::MOD_W){1'b0}}, res_r};
          out_tvalid_nxt = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
      modulus_r    <= mau_pkg::MODULUS_RESET;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_we) begin
        modulus_r <= cfg_wdata;
      end
    end
    mode_r      <= mode_nxt;
    op_a_r      <= op_a_nxt;
    op_b_r      <= op_b_nxt;
    cnt_r       <= cnt_nxt;
    red_a_r     <= red_a_nxt;
    red_b_r     <= red_b_nxt;
    mul_acc_r   <= mul_acc_nxt;
    mul_x_r     <= mul_x_nxt;
    mul_y_r     <= mul_y_nxt;
    mul_dst_r   <= mul_dst_nxt;
    pw_acc_r    <= pw_acc_nxt;
    pw_base_r   <= pw_base_nxt;
    pw_exp_r    <= pw_exp_nxt;
    pw_sq_r     <= pw_sq_nxt;
    res_r       <= res_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

endmodule

[sim/modular_arithmetic_unit_test.sv]
// Self-checking testbench for the modular arithmetic unit: add, multiply, power and the unused mode per modulus.
module modular_arithmetic_unit_test;
  import mau_pkg::*;

  // ---------------------------------------------------------------------------
  // Run constants
  // ---------------------------------------------------------------------------
  localparam int WATCHDOG_LIMIT = 40000;  // worst power plus long hold, several times over
  localparam int LONG_HOLD      = 1500;   // receiver hold-off during the squeeze phase
  localparam int SIDE_SEND      = 0;
  localparam int SIDE_RECV      = 1;
  localparam logic [DATA_WIDTH-1:0] OPERAND_ONES = '1;

  typedef struct {
    mode_t                 mode;
    logic [DATA_WIDTH-1:0] a;
    logic [DATA_WIDTH-1:0] b;
  } mau_request_t;

  // ---------------------------------------------------------------------------
  // DUT signals; the ones the testbench drives are known from time zero
  // ---------------------------------------------------------------------------
  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // [62:0] operand_a, [125:63] operand_b
  logic [1:0]            in_tuser = '0;   // [1:0] mode
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // [61:0] result
  logic                  cfg_we = 1'b0;
  logic [MOD_W-1:0]      cfg_wdata = '0;

  // ---------------------------------------------------------------------------
  // Testbench state
  // ---------------------------------------------------------------------------
  mau_request_t     pending_requests[$];   // filled by the sequence, drained by the driver
  logic [MOD_W-1:0] expected_residues[$];  // one per accepted request, oldest first
  logic [MOD_W-1:0] modulus_copy = MODULUS_RESET;
  mau_request_t     live_request;
  bit               offer_live = 1'b0;     // driver holds a request on the bus
  int               send_wait = 0;
  int               recv_wait = 0;
  int               calm_left[2] = '{0, 0};
  int               results_seen = 0;
  int               squeeze_at = -1;       // result count that triggers the long hold
  int               fault_count = 0;
  int               quiet_cycles = 0;

  modular_arithmetic_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor: wide arithmetic stands in for the shift-and-add datapath.
  // Products of two residues stay below 2^124, so 128 bits never overflow.
  // ---------------------------------------------------------------------------
  function automatic logic [MOD_W-1:0] predict_residue(input mau_request_t r,
                                                       input logic [MOD_W-1:0] m);
    logic [127:0]          wm;
    logic [127:0]          x;
    logic [127:0]          y;
    logic [127:0]          acc;
    logic [DATA_WIDTH-1:0] e;
    wm = 128'(m);
    // modulus zero and the unused mode both return zero
    if (wm == 0 || r.mode == MODE_NOP) return '0;
    x = 128'(r.a) % wm;
    y = 128'(r.b) % wm;
    case (r.mode)
      MODE_ADD: acc = (x + y) % wm;
      MODE_MUL: acc = (x * y) % wm;
      default: begin
        // square-and-multiply from the exponent LSB; e = 0 gives 1 mod m
        acc = 128'd1 % wm;
        e = r.b;
        while (e != 0) begin
          if (e[0]) acc = (acc * x) % wm;
          x = (x * x) % wm;
          e = e >> 1;
        end
      end
    endcase
    return acc[MOD_W-1:0];
  endfunction

  // Random wait before the next request or result, with occasional runs of back-to-back ones.
  function automatic int draw_wait(input int side);
    if (calm_left[side] > 0) begin
      calm_left[side]--;
      return 0;
    end
    if ($urandom_range(0, 5) == 0) calm_left[side] = $urandom_range(4, 12);
    return $urandom_range(0, 19);
  endfunction

  task automatic log_fault(input string msg);
    fault_count++;
    if (fault_count <= 10) $display("%s", msg);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers queued requests, predicts each one at its accepting edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      offer_live = 1'b0;
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= '0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_residues = {expected_residues, predict_residue(live_request, modulus_copy)};
        offer_live = 1'b0;
        send_wait = draw_wait(SIDE_SEND);
      end
      if (!offer_live) begin
        if (send_wait > 0) begin
          send_wait--;
        end else if (pending_requests.size() > 0) begin
          live_request = pending_requests.pop_front();
          offer_live = 1'b1;
          in_tdata <= {{(IN_DATA_W - 2 * DATA_WIDTH){1'b0}}, live_request.b, live_request.a};
          in_tuser <= live_request.mode;
        end
      end
      // single assignment per edge keeps valid steady across back-to-back requests
      in_tvalid <= offer_live;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: takes results with random stalls, checks against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    logic [MOD_W-1:0] want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (expected_residues.size() == 0) begin
          log_fault($sformatf("unexpected result 0x%016h, no request outstanding", out_tdata));
        end else begin
          want = expected_residues.pop_front();
          if (out_tdata[MOD_W-1:0] !== want)
            log_fault($sformatf("result #%0d mismatch: expected 0x%016h, got 0x%016h",
                                results_seen, want, out_tdata[MOD_W-1:0]));
        end
        recv_wait = draw_wait(SIDE_RECV);
        // squeeze: hold off long enough for the unit to fill and block its input
        if (results_seen == squeeze_at) recv_wait = LONG_HOLD;
      end else if (recv_wait > 0) begin
        recv_wait--;
      end
      out_tready <= (recv_wait == 0);
    end
  end

  // Watchdog: any accepted request or result restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_request(input mode_t mode, input logic [DATA_WIDTH-1:0] a,
                               input logic [DATA_WIDTH-1:0] b);
    mau_request_t r;
    r.mode = mode;
    r.a = a;
    r.b = b;
    pending_requests = {pending_requests, r};
  endtask

  // Operands: zero, all ones, around the modulus, small, or full width.
  function automatic logic [DATA_WIDTH-1:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return OPERAND_ONES;
      2: return DATA_WIDTH'(modulus_copy) - DATA_WIDTH'($urandom_range(0, 1));
      3: return DATA_WIDTH'(modulus_copy) + DATA_WIDTH'($urandom_range(1, 2));
      4: return DATA_WIDTH'($urandom_range(0, 65535));
      default: return DATA_WIDTH'({$urandom, $urandom});
    endcase
  endfunction

  // Exponents stay short mostly; one draw in eight is full width.
  function automatic logic [DATA_WIDTH-1:0] pick_exponent();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return DATA_WIDTH'($urandom_range(1, 64));
      7: return DATA_WIDTH'({$urandom, $urandom});
      default: return DATA_WIDTH'($urandom_range(0, 4095));
    endcase
  endfunction

  task automatic queue_random(input bit arith_only);
    mode_t mode;
    int    pick;
    pick = $urandom_range(0, arith_only ? 5 : 9);
    mode = (pick < 3) ? MODE_ADD : (pick < 6) ? MODE_MUL : (pick < 9) ? MODE_POW : MODE_NOP;
    queue_request(mode, pick_operand(), (mode == MODE_POW) ? pick_exponent() : pick_operand());
  endtask

  // Idle means nothing queued, nothing offered and nothing owed.
  task automatic wait_idle();
    do @(posedge clk);
    while (pending_requests.size() != 0 || offer_live || expected_residues.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_modulus(input logic [MOD_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    modulus_copy = value;
  endtask

  // One phase: new modulus, an exponent-zero power unless arith_only, then random requests.
  task automatic run_phase(input logic [MOD_W-1:0] m, input int count, input bit arith_only);
    write_modulus(m);
    if (!arith_only) queue_request(MODE_POW, pick_operand(), '0);
    for (int i = 0; i < count; i++) queue_random(arith_only);
    wait_idle();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [MOD_W-1:0] m_reset;
    m_reset = MODULUS_RESET;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners under the reset modulus
    queue_request(MODE_ADD, '0, '0);
    queue_request(MODE_ADD, OPERAND_ONES, OPERAND_ONES);
    queue_request(MODE_ADD, OPERAND_ONES, '0);
    queue_request(MODE_ADD, DATA_WIDTH'(m_reset) - 1, DATA_WIDTH'(1));
    queue_request(MODE_ADD, DATA_WIDTH'(m_reset), DATA_WIDTH'(m_reset));
    queue_request(MODE_MUL, '0, OPERAND_ONES);
    queue_request(MODE_MUL, OPERAND_ONES, OPERAND_ONES);
    queue_request(MODE_MUL, DATA_WIDTH'(m_reset) - 1, DATA_WIDTH'(m_reset) - 1);
    queue_request(MODE_MUL, DATA_WIDTH'(1), DATA_WIDTH'(m_reset) + 1);
    queue_request(MODE_POW, '0, '0);                    // 0^0 gives 1
    queue_request(MODE_POW, '0, DATA_WIDTH'(1));
    queue_request(MODE_POW, DATA_WIDTH'(2), DATA_WIDTH'(10));
    queue_request(MODE_POW, DATA_WIDTH'(m_reset) - 1, DATA_WIDTH'(2));
    queue_request(MODE_POW, DATA_WIDTH'(3), DATA_WIDTH'(m_reset) - 2); // Fermat inverse
    queue_request(MODE_POW, DATA_WIDTH'(m_reset), DATA_WIDTH'(5));
    queue_request(MODE_POW, OPERAND_ONES, OPERAND_ONES);  // longest exponent
    queue_request(MODE_NOP, OPERAND_ONES, OPERAND_ONES);
    queue_request(MODE_NOP, '0, '0);
    for (int i = 0; i < 18; i++) queue_random(1'b0);
    wait_idle();

    run_phase(62'd2, 12, 1'b0);                           // smallest useful modulus
    run_phase('1, 14, 1'b0);                              // largest modulus
    run_phase('0, 8, 1'b0);                               // modulus zero: all results 0
    run_phase(62'd1, 8, 1'b0);                            // modulus one: even x^0 is 0
    run_phase({1'b1, 61'({$urandom, $urandom})}, 12, 1'b0);
    run_phase(MOD_W'($urandom_range(3, 255)), 10, 1'b0);

    // squeeze: long receiver hold after the first result of this phase
    squeeze_at = results_seen + 1;
    run_phase(MOD_W'($urandom_range(2, 1 << 20)), 10, 1'b1);

    run_phase(m_reset, 8, 1'b0);                          // back to the reset value

    // let any stray result show up before closing
    repeat (40) @(posedge clk);
    if (expected_residues.size() != 0)
      log_fault($sformatf("%0d results never arrived", expected_residues.size()));

    if (fault_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
